[sv/blsc_pkg.sv]
// Package for the battery load-shedding controller.
// Holds the mode codes, configuration register indexes and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package blsc_pkg;

  localparam int unsigned CODE_W     = 10;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SW_W       = 4;
  localparam int unsigned RELAY_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Power modes as seen on the result channel
  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_TOO_LOW  = 3'd1,
    MODE_LOW      = 3'd2,
    MODE_SLEEP    = 3'd3,
    MODE_STANDBY  = 3'd4,
    MODE_CHARGING = 3'd5,
    MODE_CHARGED  = 3'd6
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STANDBY_LEVEL   = 3'd0,
    CFG_CHARGING_LEVEL  = 3'd1,
    CFG_BAT_LOW_LEVEL   = 3'd2,
    CFG_BAT_TOO_LOW_LVL = 3'd3,
    CFG_TOO_LOW_LIMIT   = 3'd4
  } cfg_idx_t;

  // Reset values of the thresholds
  localparam logic [CODE_W-1:0]  STANDBY_LEVEL_RST   = 10'd79;
  localparam logic [CODE_W-1:0]  CHARGING_LEVEL_RST  = 10'd514;
  localparam logic [CODE_W-1:0]  BAT_LOW_LEVEL_RST   = 10'd419;
  localparam logic [CODE_W-1:0]  BAT_TOO_LOW_LVL_RST = 10'd400;
  localparam logic [COUNT_W-1:0] TOO_LOW_LIMIT_RST   = 16'd100;

  // Switch bits: 0 permanent, 1 radio, 2 high load, 3 low load
  localparam int unsigned SW_PERM  = 0;
  localparam int unsigned SW_RADIO = 1;
  localparam int unsigned SW_HIGH  = 2;
  localparam int unsigned SW_LOW   = 3;

  // Relay bits: 0 radio, 1 high, 2 low, 3 charge
  localparam int unsigned RL_RADIO  = 0;
  localparam int unsigned RL_HIGH   = 1;
  localparam int unsigned RL_LOW    = 2;
  localparam int unsigned RL_CHARGE = 3;

  typedef struct packed {
    logic [CODE_W-1:0]  standby_level;
    logic [CODE_W-1:0]  charging_level;
    logic [CODE_W-1:0]  bat_low_level;
    logic [CODE_W-1:0]  bat_too_low_level;
    logic [COUNT_W-1:0] too_low_limit;
  } cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] battery_code;
    logic [CODE_W-1:0] vehicle_code;
    logic [SW_W-1:0]   sw;
  } sample_t;

  // Controller state carried from one sample to the next
  typedef struct packed {
    mode_t              mode;
    logic [COUNT_W-1:0] crit_cnt;
    logic [SW_W-1:0]    last_sw;
    logic [RELAY_W-1:0] relay;
    logic               slow;
  } ctl_state_t;

endpackage

[sv/blsc_if.sv]
// Channel interfaces for the battery load-shedding controller:
// sample input, result output and configuration write.
// Depends on blsc_pkg.
`timescale 1ns / 1ps

interface blsc_in_if;
  import blsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] battery_code;
  logic [CODE_W-1:0] vehicle_code;
  logic              permanent_switch;
  logic              radio_switch;
  logic              high_load_switch;
  logic              low_load_switch;

  modport source (output valid, battery_code, vehicle_code, permanent_switch,
                  radio_switch, high_load_switch, low_load_switch, input ready);
  modport sink   (input valid, battery_code, vehicle_code, permanent_switch,
                  radio_switch, high_load_switch, low_load_switch, output ready);
endinterface

interface blsc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic       radio_relay;
  logic       high_relay;
  logic       low_relay;
  logic       charge_relay;
  logic       slow_sampling;
  logic       refreshed;

  modport source (output valid, mode, radio_relay, high_relay, low_relay,
                  charge_relay, slow_sampling, refreshed, input ready);
  modport sink   (input valid, mode, radio_relay, high_relay, low_relay,
                  charge_relay, slow_sampling, refreshed, output ready);
endinterface

interface blsc_cfg_if;
  import blsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[sv/blsc_mode_calc.sv]
// Mode classification and relay decision for one sample.
// Pure combinational: current state and sample in, next state out.
// Depends on blsc_pkg.
`timescale 1ns / 1ps

module blsc_mode_calc (
  input  blsc_pkg::cfg_t       cfg,
  input  blsc_pkg::sample_t    sample,
  input  blsc_pkg::ctl_state_t cur,
  output blsc_pkg::ctl_state_t nxt,
  output logic                 refresh
);
  import blsc_pkg::*;

  logic               bat_low;
  logic               bat_crit;
  logic               veh_awake;
  logic               veh_charging;
  logic [COUNT_W-1:0] cnt_up;
  logic [COUNT_W-1:0] cnt_dn;
  logic [RELAY_W-1:0] low_rule;
  logic [2:0]         loads;
  mode_t              mode_nxt;
  logic [COUNT_W-1:0] cnt_nxt;

  // Threshold compares
  assign bat_low      = sample.battery_code < cfg.bat_low_level;
  assign bat_crit     = sample.battery_code < cfg.bat_too_low_level;
  assign veh_awake    = sample.vehicle_code >= cfg.standby_level;
  assign veh_charging = sample.vehicle_code >= cfg.charging_level;

  // Saturating up/down count of critical samples
  assign cnt_up = (cur.crit_cnt == '1) ? cur.crit_cnt : cur.crit_cnt + 1'b1;
  assign cnt_dn = (cur.crit_cnt == '0) ? cur.crit_cnt : cur.crit_cnt - 1'b1;

  // Mode classification
  always_comb begin
    mode_nxt = cur.mode;
    cnt_nxt  = cnt_dn;
    if (bat_low) begin
      if (bat_crit) begin
        cnt_nxt  = cnt_up;
        mode_nxt = (cnt_up > cfg.too_low_limit) ? MODE_TOO_LOW : MODE_LOW;
      end else begin
        mode_nxt = MODE_LOW;
      end
      if (veh_charging) begin
        cnt_nxt  = '0;
        mode_nxt = MODE_CHARGING;
      end
    end else if (!veh_awake) begin
      mode_nxt = MODE_SLEEP;
    end else if (!veh_charging) begin
      if (cur.mode == MODE_CHARGING) mode_nxt = MODE_CHARGED;
      else if (cur.mode == MODE_LOW) mode_nxt = MODE_LOW;
      else mode_nxt = MODE_STANDBY;
    end else begin
      mode_nxt = MODE_CHARGING;
    end
  end

  assign refresh = (mode_nxt != cur.mode) || (sample.sw != cur.last_sw);

  // Low battery: at most one load, by switch priority
  always_comb begin
    low_rule = '0;
    if (sample.sw[SW_PERM])      low_rule[RL_RADIO] = 1'b1;
    else if (sample.sw[SW_HIGH]) low_rule[RL_HIGH]  = 1'b1;
    else if (sample.sw[SW_LOW])  low_rule[RL_LOW]   = 1'b1;
  end

  assign loads = sample.sw[SW_LOW:SW_RADIO];

  // Relay and sampling-rate decision, held unless refreshed
  always_comb begin
    nxt.mode     = mode_nxt;
    nxt.crit_cnt = cnt_nxt;
    nxt.last_sw  = sample.sw;
    nxt.relay    = cur.relay;
    nxt.slow     = cur.slow;
    if (refresh) begin
      case (mode_nxt)
        MODE_TOO_LOW: begin
          nxt.relay = '0;
          nxt.slow  = 1'b1;
        end
        MODE_LOW: begin
          nxt.relay = low_rule;
          nxt.slow  = 1'b1;
        end
        MODE_SLEEP: begin
          nxt.relay = sample.sw[SW_PERM] ? {1'b0, loads} : '0;
          nxt.slow  = 1'b1;
        end
        MODE_STANDBY, MODE_CHARGED: begin
          nxt.relay = {1'b0, loads};
          nxt.slow  = 1'b0;
        end
        MODE_CHARGING: begin
          nxt.relay = {1'b1, loads};
          nxt.slow  = 1'b0;
        end
        default: begin
          // start mode: low rule, slow flag held
          nxt.relay = low_rule;
        end
      endcase
    end
  end

endmodule

[sv/battery_load_shedding_controller.sv]
// Battery load-shedding controller: top level with channel handshakes and state.
// Depends on blsc_pkg, blsc_if and blsc_mode_calc.
`timescale 1ns / 1ps

// One sample is accepted every clock cycle when the result side keeps up; each
// sample passes through the input register, then the result register. The mode,
// critical count, switch history and relay state are updated as each sample
// leaves the input register, so samples follow each other with no gap.
// Configuration writes are always accepted and must only be made while no
// sample is in flight.
module battery_load_shedding_controller (
  input logic            clk,
  input logic            rst_n,
  blsc_in_if.sink        in_s,
  blsc_out_if.source     out_m,
  blsc_cfg_if.sink       cfg_s
);
  import blsc_pkg::*;

  cfg_t       cfg_r;
  logic       s1_valid_r;
  sample_t    s1_sample_r;
  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       refresh;
  logic       out_valid_r;
  logic       out_refresh_r;
  logic       advance;
  logic       in_ready;

  // Pipeline moves when the result register is free or being emptied
  assign advance  = !out_valid_r || out_m.ready;
  assign in_ready = !s1_valid_r || advance;

  assign in_s.ready  = in_ready;
  assign cfg_s.ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.standby_level     <= STANDBY_LEVEL_RST;
      cfg_r.charging_level    <= CHARGING_LEVEL_RST;
      cfg_r.bat_low_level     <= BAT_LOW_LEVEL_RST;
      cfg_r.bat_too_low_level <= BAT_TOO_LOW_LVL_RST;
      cfg_r.too_low_limit     <= TOO_LOW_LIMIT_RST;
    end else if (cfg_s.valid) begin
      unique case (cfg_s.index)
        CFG_STANDBY_LEVEL:   cfg_r.standby_level     <= cfg_s.data[CODE_W-1:0];
        CFG_CHARGING_LEVEL:  cfg_r.charging_level    <= cfg_s.data[CODE_W-1:0];
        CFG_BAT_LOW_LEVEL:   cfg_r.bat_low_level     <= cfg_s.data[CODE_W-1:0];
        CFG_BAT_TOO_LOW_LVL: cfg_r.bat_too_low_level <= cfg_s.data[CODE_W-1:0];
        CFG_TOO_LOW_LIMIT:   cfg_r.too_low_limit     <= cfg_s.data[COUNT_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_s.valid) begin
      s1_sample_r.battery_code <= in_s.battery_code;
      s1_sample_r.vehicle_code <= in_s.vehicle_code;
      s1_sample_r.sw           <= {in_s.low_load_switch, in_s.high_load_switch,
                                   in_s.radio_switch, in_s.permanent_switch};
    end
  end

  blsc_mode_calc u_calc (
    .cfg     (cfg_r),
    .sample  (s1_sample_r),
    .cur     (state_r),
    .nxt     (state_nxt),
    .refresh (refresh)
  );

  // Controller state, updated as each sample moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode     <= MODE_START;
      state_r.crit_cnt <= '0;
      state_r.last_sw  <= '0;
      state_r.relay    <= '0;
      state_r.slow     <= 1'b0;
    end else if (s1_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_refresh_r <= refresh;
    end
  end

  // The result payload is the state just written plus the refresh flag
  assign out_m.valid         = out_valid_r;
  assign out_m.mode          = state_r.mode;
  assign out_m.radio_relay   = state_r.relay[RL_RADIO];
  assign out_m.high_relay    = state_r.relay[RL_HIGH];
  assign out_m.low_relay     = state_r.relay[RL_LOW];
  assign out_m.charge_relay  = state_r.relay[RL_CHARGE];
  assign out_m.slow_sampling = state_r.slow;
  assign out_m.refreshed     = out_refresh_r;

endmodule

[sv/blsc_checker.sv]
// Port-level checks for the battery load-shedding controller, bound to the top.
// Depends on blsc_pkg.
`timescale 1ns / 1ps

module blsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [2:0] out_mode,
  input logic       out_radio_relay,
  input logic       out_high_relay,
  input logic       out_low_relay,
  input logic       out_charge_relay,
  input logic       out_slow_sampling
);
  import blsc_pkg::*;

  // Start mode never survives a sample
  a_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mode != MODE_START))
    else $error("start mode reported on a result");

  // Charge relay is on exactly in charging mode
  a_charge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_charge_relay == (out_mode == MODE_CHARGING)))
    else $error("charge relay disagrees with mode");

  // Too-low mode sheds every load
  a_too_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mode == MODE_TOO_LOW) |->
      !(out_radio_relay || out_high_relay || out_low_relay))
    else $error("load relay on in too-low mode");

  // Slow sampling follows the mode class
  a_slow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_slow_sampling == (out_mode == MODE_TOO_LOW ||
                                         out_mode == MODE_LOW ||
                                         out_mode == MODE_SLEEP)))
    else $error("slow sampling flag disagrees with mode");

endmodule

bind battery_load_shedding_controller blsc_checker u_blsc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_m.valid),
  .out_mode          (out_m.mode),
  .out_radio_relay   (out_m.radio_relay),
  .out_high_relay    (out_m.high_relay),
  .out_low_relay     (out_m.low_relay),
  .out_charge_relay  (out_m.charge_relay),
  .out_slow_sampling (out_m.slow_sampling)
);

[tb/tb_top.sv]
// Self-checking testbench for the battery load-shedding controller: random and directed
// samples are predicted in the bench and compared with every result transaction.
// Depends on blsc_pkg, blsc_if and battery_load_shedding_controller.
`timescale 1ns / 1ps

module tb_top;
  import blsc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 90;
  localparam int unsigned CRIT_RUN       = 8;
  // Index with no register behind it: writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef enum {BAT_CRITICAL, BAT_LOW, BAT_HEALTHY} bat_band_e;
  typedef enum {VEH_ASLEEP, VEH_AWAKE, VEH_CHARGING} veh_band_e;
  typedef enum {SEG_DRAIN, SEG_CHARGE_CYCLE, SEG_LOW_HOLD, SEG_SLEEP, SEG_STANDBY,
                SEG_NOISE} seg_kind_e;

  typedef struct packed {
    mode_t mode;
    logic  radio_relay;
    logic  high_relay;
    logic  low_relay;
    logic  charge_relay;
    logic  slow_sampling;
    logic  refreshed;
  } power_result_t;

  logic clk = 1'b0;
  logic rst_n;

  blsc_in_if  in_ch ();
  blsc_out_if out_ch ();
  blsc_cfg_if cfg_ch ();

  battery_load_shedding_controller dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_ch),
    .out_m (out_ch),
    .cfg_s (cfg_ch)
  );

  // Stimulus and expectation stores
  sample_t       sample_q[$];
  power_result_t pending_results[$];
  int unsigned   queued_total = 0;
  int unsigned   taken_total  = 0;
  int unsigned   idle_cycles  = 0;
  int            err_cnt      = 0;
  int            send_idle_pct;
  int            recv_idle_pct;
  logic          hold_req;
  logic          hold_ack;
  int unsigned   hold_left;

  // Predicted controller state and thresholds
  cfg_t               lvl;
  mode_t              ctl_mode;
  logic [COUNT_W-1:0] crit_cnt;
  logic [SW_W-1:0]    last_sw;
  logic [RELAY_W-1:0] relays;
  logic               slow_flag;

  // Clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Low-battery shedding: only the first active of permanent, high, low survives
  function automatic logic [RELAY_W-1:0] shed_pick(input logic [SW_W-1:0] sw);
    logic [RELAY_W-1:0] r;
    r = '0;
    if (sw[SW_PERM]) r[RL_RADIO] = 1'b1;
    else if (sw[SW_HIGH]) r[RL_HIGH] = 1'b1;
    else if (sw[SW_LOW]) r[RL_LOW] = 1'b1;
    return r;
  endfunction

  // Advance the predicted controller by one sample and give its result
  task automatic advance_controller(input sample_t s, output power_result_t r);
    mode_t              prev_mode;
    mode_t              nxt_mode;
    logic [RELAY_W-1:0] loads;
    logic               refresh;
    prev_mode = ctl_mode;
    nxt_mode  = prev_mode;
    if (s.battery_code < lvl.bat_low_level) begin
      if (s.battery_code < lvl.bat_too_low_level) begin
        if (crit_cnt != 16'hFFFF) crit_cnt = crit_cnt + 1'b1;
        if (crit_cnt > lvl.too_low_limit) nxt_mode = MODE_TOO_LOW;
        else nxt_mode = MODE_LOW;
      end else begin
        if (crit_cnt != '0) crit_cnt = crit_cnt - 1'b1;
        nxt_mode = MODE_LOW;
      end
      // charging overrides and clears the critical count
      if (s.vehicle_code >= lvl.charging_level) begin
        crit_cnt = '0;
        nxt_mode = MODE_CHARGING;
      end
    end else begin
      if (crit_cnt != '0) crit_cnt = crit_cnt - 1'b1;
      if (s.vehicle_code < lvl.standby_level) nxt_mode = MODE_SLEEP;
      else if (s.vehicle_code < lvl.charging_level) begin
        if (prev_mode == MODE_CHARGING) nxt_mode = MODE_CHARGED;
        else if (prev_mode == MODE_LOW) nxt_mode = MODE_LOW;
        else nxt_mode = MODE_STANDBY;
      end else nxt_mode = MODE_CHARGING;
    end

    refresh  = (nxt_mode != prev_mode) || (s.sw != last_sw);
    last_sw  = s.sw;
    ctl_mode = nxt_mode;

    loads            = '0;
    loads[RL_RADIO]  = s.sw[SW_RADIO];
    loads[RL_HIGH]   = s.sw[SW_HIGH];
    loads[RL_LOW]    = s.sw[SW_LOW];
    if (refresh) begin
      case (nxt_mode)
        MODE_TOO_LOW: begin
          relays    = '0;
          slow_flag = 1'b1;
        end
        MODE_LOW: begin
          relays    = shed_pick(s.sw);
          slow_flag = 1'b1;
        end
        MODE_SLEEP: begin
          relays    = s.sw[SW_PERM] ? loads : '0;
          slow_flag = 1'b1;
        end
        MODE_STANDBY, MODE_CHARGED: begin
          relays    = loads;
          slow_flag = 1'b0;
        end
        MODE_CHARGING: begin
          relays             = loads;
          relays[RL_CHARGE]  = 1'b1;
          slow_flag          = 1'b0;
        end
        default: begin
          relays = shed_pick(s.sw);
        end
      endcase
    end

    r.mode          = nxt_mode;
    r.radio_relay   = relays[RL_RADIO];
    r.high_relay    = relays[RL_HIGH];
    r.low_relay     = relays[RL_LOW];
    r.charge_relay  = relays[RL_CHARGE];
    r.slow_sampling = slow_flag;
    r.refreshed     = refresh;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Sample driver: pops pending samples, idles at random
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s = sample_q.pop_front();
        in_ch.valid            <= 1'b1;
        in_ch.battery_code     <= s.battery_code;
        in_ch.vehicle_code     <= s.vehicle_code;
        in_ch.permanent_switch <= s.sw[SW_PERM];
        in_ch.radio_switch     <= s.sw[SW_RADIO];
        in_ch.high_load_switch <= s.sw[SW_HIGH];
        in_ch.low_load_switch  <= s.sw[SW_LOW];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result ready: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_ack     <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Prediction on accepted samples, checking of accepted results, watchdog
  always @(posedge clk) begin : scoreboard
    sample_t       s;
    power_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        s.battery_code = in_ch.battery_code;
        s.vehicle_code = in_ch.vehicle_code;
        s.sw[SW_PERM]  = in_ch.permanent_switch;
        s.sw[SW_RADIO] = in_ch.radio_switch;
        s.sw[SW_HIGH]  = in_ch.high_load_switch;
        s.sw[SW_LOW]   = in_ch.low_load_switch;
        advance_controller(s, want);
        pending_results.push_back(want);
        taken_total++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result transaction with nothing expected, actual mode %0d",
                   $time, out_ch.mode);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          compare_field("mode", want.mode, out_ch.mode);
          compare_field("radio_relay", want.radio_relay, out_ch.radio_relay);
          compare_field("high_relay", want.high_relay, out_ch.high_relay);
          compare_field("low_relay", want.low_relay, out_ch.low_relay);
          compare_field("charge_relay", want.charge_relay, out_ch.charge_relay);
          compare_field("slow_sampling", want.slow_sampling, out_ch.slow_sampling);
          compare_field("refreshed", want.refreshed, out_ch.refreshed);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Register write; caller lowers valid after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_STANDBY_LEVEL:   lvl.standby_level     = value[CODE_W-1:0];
      CFG_CHARGING_LEVEL:  lvl.charging_level    = value[CODE_W-1:0];
      CFG_BAT_LOW_LEVEL:   lvl.bat_low_level     = value[CODE_W-1:0];
      CFG_BAT_TOO_LOW_LVL: lvl.bat_too_low_level = value[CODE_W-1:0];
      CFG_TOO_LOW_LIMIT:   lvl.too_low_limit     = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Upper data bits are junk on the 10-bit registers, the block must drop them
  task automatic apply_setting(input int stb, input int chg, input int blow, input int btl,
                               input int lim);
    write_reg(CFG_STANDBY_LEVEL,   {6'($urandom), stb[CODE_W-1:0]});
    write_reg(CFG_CHARGING_LEVEL,  {6'($urandom), chg[CODE_W-1:0]});
    write_reg(CFG_BAT_LOW_LEVEL,   {6'($urandom), blow[CODE_W-1:0]});
    write_reg(CFG_BAT_TOO_LOW_LVL, {6'($urandom), btl[CODE_W-1:0]});
    write_reg(CFG_TOO_LOW_LIMIT,   lim[COUNT_W-1:0]);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (taken_total != queued_total || pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_sample(input int bat, input int veh, input logic [SW_W-1:0] sw);
    sample_t s;
    s.battery_code = bat[CODE_W-1:0];
    s.vehicle_code = veh[CODE_W-1:0];
    s.sw           = sw;
    sample_q.push_back(s);
    queued_total++;
  endtask

  function automatic int rand_between(input int lo, input int hi);
    if (lo > hi) return $urandom_range(1023, 0);
    return $urandom_range(hi, lo);
  endfunction

  function automatic int pick_battery(input bat_band_e b);
    case (b)
      BAT_CRITICAL: return rand_between(0, int'(lvl.bat_too_low_level) - 1);
      BAT_LOW:      return rand_between(lvl.bat_too_low_level, int'(lvl.bat_low_level) - 1);
      default:      return rand_between(lvl.bat_low_level, 1023);
    endcase
  endfunction

  function automatic int pick_vehicle(input veh_band_e v);
    case (v)
      VEH_ASLEEP: return rand_between(0, int'(lvl.standby_level) - 1);
      VEH_AWAKE:  return rand_between(lvl.standby_level, int'(lvl.charging_level) - 1);
      default:    return rand_between(lvl.charging_level, 1023);
    endcase
  endfunction

  // Occasional single switch flip so relays get refreshed mid-segment
  function automatic logic [SW_W-1:0] jitter_sw(input logic [SW_W-1:0] sw, input int pct);
    logic [SW_W-1:0] r;
    int              idx;
    r   = sw;
    idx = $urandom_range(SW_W-1, 0);
    if ($urandom_range(99) < pct) r[idx] = ~r[idx];
    return r;
  endfunction

  // Mostly well-formed mode sequences with random content, some pure noise
  task automatic queue_random_traffic(input int unsigned n);
    int unsigned     start;
    int              k;
    int              len;
    int              i;
    seg_kind_e       kind;
    veh_band_e       vb;
    logic [SW_W-1:0] sw;
    start = queued_total;
    while (queued_total - start < n) begin
      sw = SW_W'($urandom);
      k  = $urandom_range(9);
      if (k < 3) kind = SEG_DRAIN;
      else if (k < 5) kind = SEG_CHARGE_CYCLE;
      else if (k == 5) kind = SEG_LOW_HOLD;
      else if (k == 6) kind = SEG_SLEEP;
      else if (k == 7) kind = SEG_STANDBY;
      else kind = SEG_NOISE;
      case (kind)
        SEG_DRAIN: begin
          // run of critical samples, long enough to reach too-low when the limit is below 200
          if (lvl.too_low_limit < 200) len = int'(lvl.too_low_limit) + $urandom_range(12, 1);
          else len = $urandom_range(40, 5);
          vb = $urandom_range(1) ? VEH_ASLEEP : VEH_AWAKE;
          for (i = 0; i < len; i++) begin
            sw = jitter_sw(sw, 10);
            push_sample(pick_battery($urandom_range(15) == 0 ? BAT_LOW : BAT_CRITICAL),
                        pick_vehicle(vb), sw);
          end
        end
        SEG_CHARGE_CYCLE: begin
          len = $urandom_range(4, 1);
          for (i = 0; i < len; i++) begin
            sw = jitter_sw(sw, 15);
            push_sample(pick_battery(bat_band_e'($urandom_range(2))),
                        pick_vehicle(VEH_CHARGING), sw);
          end
          len = $urandom_range(6, 1);
          for (i = 0; i < len; i++) begin
            sw = jitter_sw(sw, 15);
            push_sample(pick_battery(BAT_HEALTHY), pick_vehicle(VEH_AWAKE), sw);
          end
          if ($urandom_range(1)) push_sample(pick_battery(BAT_HEALTHY),
                                             pick_vehicle(VEH_ASLEEP), sw);
        end
        SEG_LOW_HOLD: begin
          len = $urandom_range(4, 1);
          for (i = 0; i < len; i++) begin
            sw = jitter_sw(sw, 30);
            push_sample(pick_battery(BAT_LOW), pick_vehicle(VEH_AWAKE), sw);
          end
          len = $urandom_range(5, 1);
          for (i = 0; i < len; i++) begin
            sw = jitter_sw(sw, 15);
            push_sample(pick_battery(BAT_HEALTHY), pick_vehicle(VEH_AWAKE), sw);
          end
        end
        SEG_SLEEP: begin
          len = $urandom_range(8, 2);
          for (i = 0; i < len; i++) begin
            sw = jitter_sw(sw, 40);
            push_sample(pick_battery(BAT_HEALTHY), pick_vehicle(VEH_ASLEEP), sw);
          end
        end
        SEG_STANDBY: begin
          len = $urandom_range(6, 1);
          for (i = 0; i < len; i++) begin
            sw = jitter_sw(sw, 20);
            push_sample(pick_battery(BAT_HEALTHY), pick_vehicle(VEH_AWAKE), sw);
          end
        end
        default: begin
          len = $urandom_range(10, 1);
          for (i = 0; i < len; i++)
            push_sample($urandom_range(1023, 0), $urandom_range(1023, 0), SW_W'($urandom));
        end
      endcase
    end
  endtask

  // Directed samples at reset thresholds: boundaries and every relay rule but too-low
  task automatic queue_directed();
    push_sample(0,    0,    4'b0000);  // critical from start
    push_sample(1023, 1023, 4'b1111);  // charging, all loads
    push_sample(1023, 300,  4'b1111);  // charged after charging
    push_sample(1023, 300,  4'b1111);  // nothing changed: held
    push_sample(1023, 0,    4'b1111);  // sleep with permanent on
    push_sample(1023, 0,    4'b1110);  // sleep, permanent off
    push_sample(410,  300,  4'b1101);  // low: permanent wins
    push_sample(410,  300,  4'b1100);  // low: high load next
    push_sample(410,  300,  4'b1000);  // low: low load last
    push_sample(410,  300,  4'b0010);  // low: nothing shed-worthy
    push_sample(1023, 300,  4'b0010);  // low remembered on healthy battery
    push_sample(1023, 600,  4'b0110);  // charging from low
    push_sample(399,  600,  4'b0110);  // critical but charging clears count
    push_sample(419,  78,   4'b0110);  // just healthy, just asleep
    push_sample(418,  79,   4'b0110);  // just low, just awake
    push_sample(400,  513,  4'b1011);  // just not critical, just below charging
    push_sample(1023, 79,   4'b1011);  // low held
    push_sample(1023, 514,  4'b1011);  // just charging
    push_sample(1023, 513,  4'b1011);  // charged
    push_sample(1023, 100,  4'b0100);  // standby after charged
    push_sample(399,  0,    4'b0001);  // critical while asleep
  endtask

  initial begin : stimulus
    int i;
    lvl.standby_level     = STANDBY_LEVEL_RST;
    lvl.charging_level    = CHARGING_LEVEL_RST;
    lvl.bat_low_level     = BAT_LOW_LEVEL_RST;
    lvl.bat_too_low_level = BAT_TOO_LOW_LVL_RST;
    lvl.too_low_limit     = TOO_LOW_LIMIT_RST;
    ctl_mode  = MODE_START;
    crit_cnt  = '0;
    last_sw   = '0;
    relays    = '0;
    slow_flag = 1'b0;
    hold_req  = 1'b0;

    in_ch.valid            = 1'b0;
    in_ch.battery_code     = '0;
    in_ch.vehicle_code     = '0;
    in_ch.permanent_switch = 1'b0;
    in_ch.radio_switch     = 1'b0;
    in_ch.high_load_switch = 1'b0;
    in_ch.low_load_switch  = 1'b0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;

    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset thresholds, sender lightly idle, receiver mostly stalled
    send_idle_pct = 27;
    recv_idle_pct = 75;
    queue_directed();
    queue_random_traffic(500);
    wait_drained();

    // Tighter limit, shifted thresholds, roles swapped; sender pauses midway
    send_idle_pct = 75;
    recv_idle_pct = 27;
    apply_setting(200, 700, 600, 300, 5);
    queue_random_traffic(250);
    wait_drained();
    queue_random_traffic(250);
    wait_drained();

    // No idling: extreme and inverted thresholds
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_setting(0, 1023, 1023, 1023, 0);
    queue_random_traffic(130);
    hold_req = ~hold_req;  // receiver blocks while samples keep coming
    wait_drained();
    apply_setting(1023, 0, 0, 0, 65534);
    queue_random_traffic(130);
    wait_drained();
    apply_setting(900, 100, 200, 800, 3);
    queue_random_traffic(130);
    wait_drained();
    write_reg(CFG_UNUSED_IDX, 16'($urandom));
    apply_setting($urandom_range(1023, 0), $urandom_range(1023, 0), $urandom_range(1023, 0),
                  $urandom_range(1023, 0), $urandom_range(20, 0));
    queue_random_traffic(130);
    wait_drained();

    // Short critical run against a limit of 65534
    apply_setting(0, 1023, 1023, 1023, 65534);
    for (i = 0; i < CRIT_RUN; i++)
      push_sample($urandom_range(1022, 0), $urandom_range(1022, 0), SW_W'($urandom));
    push_sample(1023, 500, 4'b1111);
    push_sample(0, 0, 4'b1111);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/blsc_pkg.sv
sv/blsc_if.sv
sv/blsc_mode_calc.sv
sv/battery_load_shedding_controller.sv
sv/blsc_checker.sv
tb/tb_top.sv
